/* hw/rtl/b64sc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

  localparam int MaxResults = 4;
  localparam int CountW     = $clog2(MaxResults + 1);
  localparam int IdxW       = $clog2(MaxResults);

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [3:0] HELD_0 = 4'd0;
  localparam logic [3:0] HELD_2 = 4'd2;
  localparam logic [3:0] HELD_4 = 4'd4;
  localparam logic [3:0] HELD_6 = 4'd6;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  typedef out_item_t [MaxResults-1:0] res_vec_t;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  held;
    logic        err;
  } codec_state_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'd97 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'd48 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  // character to 6-bit value; bit 6 set for a non-alphabet code
  function automatic logic [6:0] dec_sextet(input logic [7:0] c);
    logic [6:0] v;
    if (c inside {[8'd65:8'd90]}) begin
      v = 7'(c - 8'd65);
    end else if (c inside {[8'd97:8'd122]}) begin
      v = 7'(c - 8'd97 + 8'd26);
    end else if (c inside {[8'd48:8'd57]}) begin
      v = 7'(c - 8'd48 + 8'd52);
    end else if (c == 8'h2b) begin
      v = 7'd62;
    end else if (c == 8'h2f) begin
      v = 7'd63;
    end else begin
      v = 7'd64;
    end
    return v;
  endfunction

  function automatic out_item_t mk_item(input logic [7:0] b);
    out_item_t r;
    r.out_byte  = b;
    r.out_valid = 1'b1;
    r.out_last  = 1'b0;
    r.out_error = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64sc_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module b64sc_step (
  input  wire logic                    mode,
  input  wire b64sc_pkg::codec_state_t st,
  input  wire b64sc_pkg::in_item_t     item,
  output b64sc_pkg::codec_state_t      st_nxt,
  output b64sc_pkg::res_vec_t          res,
  output logic [b64sc_pkg::CountW-1:0] res_cnt
);
  import b64sc_pkg::*;

  logic [11:0]       acc8;
  logic [11:0]       acc6;
  logic [6:0]        sext;
  logic              skip;
  logic [CountW-1:0] last_idx;

  always_comb begin
    res      = '0;
    res_cnt  = '0;
    st_nxt   = st;
    acc8     = {st.acc[3:0], item.data_byte};
    sext     = dec_sextet(item.data_byte);
    acc6     = {st.acc[5:0], sext[5:0]};
    skip     = item.data_byte inside {8'd32, [8'd9:8'd13], PAD_CHAR};
    last_idx = '0;

    if (mode == MODE_ENCODE) begin
      st_nxt.acc = acc8;
      case (st.held)
        HELD_4: begin
          res[0]      = mk_item(enc_char(acc8[11:6]));
          res[1]      = mk_item(enc_char(acc8[5:0]));
          res_cnt     = CountW'(2);
          st_nxt.held = HELD_0;
        end
        HELD_2: begin
          res[0]      = mk_item(enc_char(acc8[9:4]));
          res_cnt     = CountW'(1);
          st_nxt.held = HELD_4;
          if (item.end_of_message) begin
            res[1]  = mk_item(enc_char({acc8[3:0], 2'b00}));
            res[2]  = mk_item(PAD_CHAR);
            res_cnt = CountW'(3);
          end
        end
        default: begin
          res[0]      = mk_item(enc_char(acc8[7:2]));
          res_cnt     = CountW'(1);
          st_nxt.held = HELD_2;
          if (item.end_of_message) begin
            res[1]  = mk_item(enc_char({acc8[1:0], 4'b0000}));
            res[2]  = mk_item(PAD_CHAR);
            res[3]  = mk_item(PAD_CHAR);
            res_cnt = CountW'(4);
          end
        end
      endcase
    end else if (!st.err && !skip) begin
      if (sext[6]) begin
        st_nxt.err = 1'b1;
      end else begin
        st_nxt.acc = acc6;
        case (st.held)
          HELD_2: begin
            res[0]      = mk_item(acc6[7:0]);
            res_cnt     = CountW'(1);
            st_nxt.held = HELD_0;
          end
          HELD_4: begin
            res[0]      = mk_item(acc6[9:2]);
            res_cnt     = CountW'(1);
            st_nxt.held = HELD_2;
          end
          HELD_6: begin
            res[0]      = mk_item(acc6[11:4]);
            res_cnt     = CountW'(1);
            st_nxt.held = HELD_4;
          end
          default: begin
            st_nxt.held = HELD_6;
          end
        endcase
      end
    end

    if (item.end_of_message) begin
      if (res_cnt == '0) begin
        res[0].out_valid = 1'b0;
        res_cnt          = CountW'(1);
      end
      last_idx = res_cnt - CountW'(1);
      for (int i = 0; i < MaxResults; i++) begin
        if (CountW'(i) == last_idx) begin
          res[i].out_last  = 1'b1;
          res[i].out_error = st_nxt.err;
        end
      end
      st_nxt = '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_codec_unit.sv */
// The first result of a request is offered in the cycle after it is accepted.
// Throughput: a request giving k results (k is 1 to 4) holds the result buffer until its
// last result is taken; requests with one result or none stream at one per cycle while
// out_ready is high. Encoding takes no new byte while two or more results of the last
// byte still wait, as at an end of message; decoding yields at most one per character.
// Reset (rst_n low, synchronous): mode returns to encode, message state and buffer clear.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_codec_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire b64sc_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output b64sc_pkg::out_item_t      out_res,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata
);
  import b64sc_pkg::*;

  logic              mode_r;
  codec_state_t      st_r;
  codec_state_t      st_nxt;
  res_vec_t          pend_r;
  res_vec_t          res;
  logic [CountW-1:0] res_cnt;
  logic [CountW-1:0] left_r;
  logic [IdxW-1:0]   idx_r;
  logic              in_acc;
  logic              out_acc;

  b64sc_step u_step (
    .mode    (mode_r),
    .st      (st_r),
    .item    (in_data),
    .st_nxt  (st_nxt),
    .res     (res),
    .res_cnt (res_cnt)
  );

  assign out_valid = (left_r != '0);
  assign out_res   = pend_r[idx_r];
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (left_r == '0) || ((left_r == CountW'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      st_r   <= '0;
      left_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
        st_r   <= '0;
      end else if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        left_r <= res_cnt;
        idx_r  <= '0;
      end else if (out_acc) begin
        left_r <= left_r - CountW'(1);
        idx_r  <= idx_r + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_r <= res;
    end
  end

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= CountW'(MaxResults))
    else $error("result count out of range");

  a_eom_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.end_of_message |=> out_valid)
    else $error("end of message gave no result");

  a_err_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.out_error |-> out_res.out_last)
    else $error("error flag off the last result");

  a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.out_valid |-> out_res.out_last && (out_res.out_byte == 8'd0))
    else $error("bare marker not last");

endmodule

`default_nettype wire
